[design/sparse_poly_add_merge_core_macros.svh]
// ----------------------------------------------------------------------------
// sparse polynomial merge core: assertion macros
// concurrent checks used by the core's modules, removable with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLY_ADD_MERGE_CORE_MACROS_SVH
`define SPARSE_POLY_ADD_MERGE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// plain property under clock and reset
`define SPADD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the following cycle
`define SPADD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`else

`define SPADD_ASSERT(label, clk, rst_n, prop, msg)
`define SPADD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

[design/spadd_pkg.sv]
// ----------------------------------------------------------------------------
// spadd_pkg
// shared codes, constants and control types of the sparse polynomial merge core
// ----------------------------------------------------------------------------
package spadd_pkg;

	// operation codes of an input transaction
	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_RUN    = 2'd2;

	// signed q8.8 coefficient
	localparam int COEF_W = 16;
	localparam logic signed [COEF_W-1:0] COEF_MAX = 16'sh7FFF;
	localparam logic signed [COEF_W-1:0] COEF_MIN = 16'sh8000;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_a;
		logic load_b;
		logic step;
		logic clear;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic slot_free;
		logic final_term;
	} sts_t;

endpackage

[design/spadd_ram.sv]
// ----------------------------------------------------------------------------
// spadd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module spadd_ram #(
	parameter int WIDTH  = 26,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[design/spadd_ctrl.sv]
// ----------------------------------------------------------------------------
// spadd_ctrl
// controller: decodes input transactions and sequences the merge run
// ----------------------------------------------------------------------------
module spadd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  spadd_pkg::sts_t   sts,
	output spadd_pkg::cmd_t   cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic in_take;

	// input is taken only between runs
	assign in_ready = (state_q == ST_IDLE);
	assign in_take  = in_valid && in_ready;

	// command decode
	always_comb begin
		cmd        = '0;
		cmd.load_a = in_take && (operation == spadd_pkg::OP_LOAD_A);
		cmd.load_b = in_take && (operation == spadd_pkg::OP_LOAD_B);
		cmd.step   = (state_q == ST_RUN) && sts.slot_free;
		cmd.clear  = cmd.step && sts.final_term;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take && (operation == spadd_pkg::OP_RUN)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.clear) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/spadd_dp.sv]
// ----------------------------------------------------------------------------
// spadd_dp
// datapath: term rams, counts, merge compare and saturating add, output register
// ----------------------------------------------------------------------------
`include "sparse_poly_add_merge_core_macros.svh"

module spadd_dp #(
	parameter int MAX_TERMS = 32,
	parameter int EXP_BITS  = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  spadd_pkg::cmd_t                      cmd,
	output spadd_pkg::sts_t                      sts,
	input  logic signed [spadd_pkg::COEF_W-1:0]  coef,
	input  logic [EXP_BITS-1:0]                  exponent,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [spadd_pkg::COEF_W-1:0]  coef_out,
	output logic [EXP_BITS-1:0]                  exponent_out,
	output logic                                 last,
	output logic                                 empty_res,
	output logic                                 overflow
);

	localparam int CW = spadd_pkg::COEF_W;
	localparam int TW = CW + EXP_BITS;
	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int NW = $clog2(MAX_TERMS + 1);
	localparam logic [NW-1:0] FULL = NW'(MAX_TERMS);

	logic [NW-1:0] cnt_a_q, cnt_b_q, ia_q, ib_q;
	logic [NW-1:0] ia_d, ib_d, ia_n, ib_n;
	logic          drop_q;
	logic [TW-1:0] rd_a, rd_b;
	logic          a_more, b_more, take_a, take_b;
	logic signed [CW-1:0] ca, cb, sum_sat, coef_sel;
	logic [EXP_BITS-1:0]  ea, eb, exp_sel;
	logic signed [CW:0]   sum_wide;
	logic          wr_a, wr_b;
	logic          out_valid_q;

	// term stores, written at the fill count, read at the next head
	assign wr_a = cmd.load_a && (cnt_a_q < FULL);
	assign wr_b = cmd.load_b && (cnt_b_q < FULL);

	spadd_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS), .ADDR_W(AW)) u_ram_a (
		.clk   (clk),
		.we    (wr_a),
		.waddr (cnt_a_q[AW-1:0]),
		.wdata ({coef, exponent}),
		.raddr (ia_d[AW-1:0]),
		.rdata (rd_a)
	);

	spadd_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS), .ADDR_W(AW)) u_ram_b (
		.clk   (clk),
		.we    (wr_b),
		.waddr (cnt_b_q[AW-1:0]),
		.wdata ({coef, exponent}),
		.raddr (ib_d[AW-1:0]),
		.rdata (rd_b)
	);

	// head compare
	assign ca     = rd_a[TW-1:EXP_BITS];
	assign ea     = rd_a[EXP_BITS-1:0];
	assign cb     = rd_b[TW-1:EXP_BITS];
	assign eb     = rd_b[EXP_BITS-1:0];
	assign a_more = (ia_q < cnt_a_q);
	assign b_more = (ib_q < cnt_b_q);
	assign take_a = a_more && (!b_more || (ea >= eb));
	assign take_b = b_more && (!a_more || (eb >= ea));

	// saturating coefficient sum
	assign sum_wide = {ca[CW-1], ca} + {cb[CW-1], cb};
	always_comb begin
		if (sum_wide[CW] != sum_wide[CW-1]) begin
			sum_sat = sum_wide[CW] ? spadd_pkg::COEF_MIN : spadd_pkg::COEF_MAX;
		end else begin
			sum_sat = sum_wide[CW-1:0];
		end
	end

	// result term selection, zeros when both lists are empty
	always_comb begin
		if (take_a && take_b) begin
			coef_sel = sum_sat;
			exp_sel  = ea;
		end else if (take_a) begin
			coef_sel = ca;
			exp_sel  = ea;
		end else if (take_b) begin
			coef_sel = cb;
			exp_sel  = eb;
		end else begin
			coef_sel = '0;
			exp_sel  = '0;
		end
	end

	// head indices and the read address of the next head
	assign ia_n = ia_q + NW'(take_a);
	assign ib_n = ib_q + NW'(take_b);
	assign ia_d = cmd.clear ? '0 : (cmd.step ? ia_n : ia_q);
	assign ib_d = cmd.clear ? '0 : (cmd.step ? ib_n : ib_q);

	assign sts.final_term = (ia_n >= cnt_a_q) && (ib_n >= cnt_b_q);
	assign sts.slot_free  = !out_valid_q || out_ready;

	// counts, drop flag and indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			ia_q    <= '0;
			ib_q    <= '0;
			drop_q  <= 1'b0;
		end else begin
			ia_q <= ia_d;
			ib_q <= ib_d;
			if (cmd.clear) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				drop_q  <= 1'b0;
			end else begin
				if (wr_a) begin
					cnt_a_q <= cnt_a_q + NW'(1);
				end
				if (wr_b) begin
					cnt_b_q <= cnt_b_q + NW'(1);
				end
				if ((cmd.load_a && !wr_a) || (cmd.load_b && !wr_b)) begin
					drop_q <= 1'b1;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			coef_out     <= coef_sel;
			exponent_out <= exp_sel;
			last         <= sts.final_term;
			empty_res    <= !a_more && !b_more;
			overflow     <= drop_q;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	`SPADD_ASSERT(a_step_slot, clk, arst_n, !cmd.step || !out_valid_q || out_ready, "step into a busy output register")
	`SPADD_ASSERT(a_no_load_in_run, clk, arst_n, !cmd.step || !(cmd.load_a || cmd.load_b), "load during merge run")
	`SPADD_ASSERT(a_count_range, clk, arst_n, (cnt_a_q <= FULL) && (cnt_b_q <= FULL), "term count beyond capacity")
	`SPADD_ASSERT_NEXT(a_clear_done, clk, arst_n, cmd.clear, (cnt_a_q == '0) && (cnt_b_q == '0) && !drop_q && out_valid_q && last, "run end did not clear stores or mark last")

endmodule

[design/sparse_poly_add_merge_core.sv]
// ----------------------------------------------------------------------------
// sparse_poly_add_merge_core
// merges two sparse polynomials held in two term stores into one term stream
// ----------------------------------------------------------------------------
// A load transaction (operation 0 into A, 1 into B) is taken and gives no
// result; a load into a full store is dropped and raises overflow on the
// next run. A run transaction merges both lists, larger exponent first,
// equal exponents as one saturated sum, and emits one result term per cycle
// while the output is taken. A run yields count_a + count_b - matches terms,
// or the single empty-marked result of two empty lists; no input is taken
// until its last term is in the output register. The run ends by clearing
// both counts and the drop flag. Operation 3 is taken and ignored.
module sparse_poly_add_merge_core #(
	parameter int MAX_TERMS = 32,
	parameter int EXP_BITS  = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           operation,
	input  logic signed [spadd_pkg::COEF_W-1:0]  coef,
	input  logic [EXP_BITS-1:0]                  exponent,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [spadd_pkg::COEF_W-1:0]  coef_out,
	output logic [EXP_BITS-1:0]                  exponent_out,
	output logic                                 last,
	output logic                                 empty_res,
	output logic                                 overflow
);

	spadd_pkg::cmd_t cmd;
	spadd_pkg::sts_t sts;

	// transaction decode and run sequencing
	spadd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	// term stores and merge datapath
	spadd_dp #(.MAX_TERMS(MAX_TERMS), .EXP_BITS(EXP_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.coef         (coef),
		.exponent     (exponent),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.coef_out     (coef_out),
		.exponent_out (exponent_out),
		.last         (last),
		.empty_res    (empty_res),
		.overflow     (overflow)
	);

endmodule
